FILE: hdl/spiq_pkg.sv
// Shared constants, codes and result type for the sorted-insert priority queue.
package spiq_pkg;

   // Defaults for the top-level parameters.
   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Fixed field widths of the stream items and the configuration register.
   localparam int ITEM_W      = 32;
   localparam int CAP_W       = 5;
   localparam int COUNT_OUT_W = 5;
   localparam int OPCODE_W    = 2;
   localparam int STATUS_W    = 2;

   // Capacity reset value.
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Register index as decoded from csr_paddr[2].
   localparam logic REG_CAPACITY = 1'b0;

   // Operation codes; any other code acts as a query.
   localparam logic [OPCODE_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_POP   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

   // Status codes reported with each result.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // One result item.
   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic                   is_full;
      logic                   is_empty;
      logic [COUNT_OUT_W-1:0] entry_count;
      logic [ITEM_W-1:0]      front_value;
   } rsp_type;

endpackage

FILE: hdl/spiq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module spiq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/spiq_ctrl.sv
// Sequencer that walks the sorted entry store with one shared priority comparator.
module spiq_ctrl #(
   parameter int DEPTH      = spiq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = spiq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [spiq_pkg::OPCODE_W-1:0]     req_op,
   input  logic [DATA_WIDTH-1:0]             req_value,
   input  logic [spiq_pkg::ITEM_W-1:0]       req_priority,
   input  logic [spiq_pkg::CAP_W-1:0]        capacity,
   input  logic                              out_free,
   output logic                              idle,
   output logic                              res_valid,
   output spiq_pkg::rsp_type                 res,
   output logic                              ram_wr_en,
   output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ram_wr_addr,
   output logic [DATA_WIDTH+spiq_pkg::ITEM_W-1:0]     ram_wr_data,
   output logic                              ram_rd_en,
   output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ram_rd_addr,
   input  logic [DATA_WIDTH+spiq_pkg::ITEM_W-1:0]     ram_rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = CW + spiq_pkg::CAP_W;
   localparam int PW = spiq_pkg::ITEM_W;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_INSERT = 5'b00100,
      ST_FRONT  = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [AW-1:0]                 idx_ff, idx_in;
   logic [DATA_WIDTH-1:0]         val_ff, val_in;
   logic [PW-1:0]                 pri_ff, pri_in;
   logic [spiq_pkg::STATUS_W-1:0] status_ff, status_in;

   logic [CW-1:0]          count_m1;
   logic [XW-1:0]          count_x;
   logic [XW-1:0]          cap_x;
   logic [XW-1:0]          depth_x;
   logic [XW-1:0]          eff_cap_x;
   logic                   full;
   logic                   empty;
   logic [PW-1:0]          rd_pri;
   logic [DATA_WIDTH-1:0]  rd_val;
   logic                   prio_ge;
   logic [DATA_WIDTH+PW-1:0] front_ext;

   // Occupancy against the capacity, which saturates at the store depth.
   assign count_m1  = count_ff - CW'(1);
   assign count_x   = {{spiq_pkg::CAP_W{1'b0}}, count_ff};
   assign cap_x     = {{CW{1'b0}}, capacity};
   assign depth_x   = XW'(DEPTH);
   assign eff_cap_x = (cap_x > depth_x) ? depth_x : cap_x;
   assign full      = (count_x >= eff_cap_x);
   assign empty     = (count_ff == '0);

   // The shared comparator: new priority against the entry just read.
   assign rd_pri  = ram_rd_data[PW-1:0];
   assign rd_val  = ram_rd_data[DATA_WIDTH+PW-1:PW];
   assign prio_ge = ($signed(pri_ff) >= $signed(rd_pri));

   // Sequencer: scan from the served end toward the head, shifting as it goes.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      val_in      = val_ff;
      pri_in      = pri_ff;
      status_in   = status_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = {val_ff, pri_ff};
      ram_rd_en   = 1'b0;
      ram_rd_addr = count_m1[AW-1:0];
      res_valid   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               val_in    = req_value;
               pri_in    = req_priority;
               status_in = spiq_pkg::STATUS_OK;
               state_in  = ST_FRONT;
               if (req_op == spiq_pkg::OP_PUSH) begin
                  if (full) begin
                     status_in = spiq_pkg::STATUS_FULL;
                  end else if (empty) begin
                     idx_in   = '0;
                     state_in = ST_INSERT;
                  end else begin
                     idx_in    = count_m1[AW-1:0];
                     ram_rd_en = 1'b1;
                     state_in  = ST_SCAN;
                  end
               end else if (req_op == spiq_pkg::OP_POP) begin
                  if (empty) begin
                     status_in = spiq_pkg::STATUS_EMPTY;
                  end else begin
                     count_in = count_m1;
                  end
               end else begin
                  if (empty) begin
                     status_in = spiq_pkg::STATUS_EMPTY;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (prio_ge) begin
               // Entry moves one place back; keep walking toward the head.
               ram_wr_en   = 1'b1;
               ram_wr_addr = idx_ff + AW'(1);
               ram_wr_data = ram_rd_data;
               if (idx_ff == '0) begin
                  state_in = ST_INSERT;
               end else begin
                  idx_in      = idx_ff - AW'(1);
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = idx_ff - AW'(1);
               end
            end else begin
               idx_in   = idx_ff + AW'(1);
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            ram_wr_en = 1'b1;
            count_in  = count_ff + CW'(1);
            state_in  = ST_FRONT;
         end
         ST_FRONT: begin
            ram_rd_en = !empty;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result fields from the count and the entry read at the served end.
   assign front_ext = {{PW{1'b0}}, rd_val};
   always_comb begin
      res.front_value = empty ? '0 : front_ext[PW-1:0];
      res.entry_count = count_x[spiq_pkg::COUNT_OUT_W-1:0];
      res.is_empty    = empty;
      res.is_full     = full;
      res.status      = status_ff;
   end

   assign idle = (state_ff == ST_IDLE);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         status_ff <= spiq_pkg::STATUS_OK;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

   // Operands of the item at work.
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      val_ff <= val_in;
      pri_ff <= pri_in;
   end

endmodule

FILE: hdl/sorted_insert_priority_queue_top.sv
// Top level of the sorted-insert priority queue: stream ports, CSR port, output register.
//
// Usage: operations arrive on the req_ stream (opcode in req_tuser, value and
// priority in req_tdata); each accepted transfer yields exactly one result on
// the rsp_ stream with the front value, count, empty/full flags and status.
// The capacity register at CSR byte address 0 limits how many entries are used;
// it saturates at DEPTH and should be written only while the queue is idle.
// Flow: one item is worked on at a time and req_tready is high only when the
// sequencer is idle. A pop, a query or a refused push reads the front entry and
// then waits to hand over its result. A push into an empty queue first writes
// the new entry; otherwise it first scans the store from the served end, moving
// each stored entry with a priority no higher than the new one one place back,
// and then writes the new entry. The walk is bounded by the single read port and
// single comparator of the entry store; the next item is taken in the cycle
// after the result is loaded into the output register.
// Reset empties the queue, sets capacity to 16 and drops any pending result.
// The entry store itself is not cleared; only entries below the count are read.
// If the receiver stalls, the result waits in the output register and the
// sequencer holds its last step until that register frees up.
module sorted_insert_priority_queue_top #(
   parameter int DEPTH      = spiq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = spiq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // item_value [31:0], item_priority [63:32]
   input  logic [1:0]  req_tuser,    // opcode [1:0]
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // front_value [31:0], entry_count [36:32],
                                     // is_empty [37], is_full [38], status [40:39]
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EW = DATA_WIDTH + spiq_pkg::ITEM_W;

   logic [spiq_pkg::CAP_W-1:0] capacity_ff, capacity_in;
   spiq_pkg::rsp_type          rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic                       start;
   logic                       idle;
   logic                       out_free;
   logic                       res_valid;
   spiq_pkg::rsp_type          res;
   logic [DATA_WIDTH+31:0]     value_ext;
   logic [DATA_WIDTH-1:0]      value_fit;
   logic                       csr_write;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [EW-1:0] ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [EW-1:0] ram_rd_data;

   // Capacity register, written on the access phase of a CSR transfer.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   always_comb begin
      capacity_in = capacity_ff;
      if (csr_write && (csr_paddr[2] == spiq_pkg::REG_CAPACITY)) begin
         capacity_in = csr_pwdata[spiq_pkg::CAP_W-1:0];
      end
   end
   assign csr_prdata = (csr_paddr[2] == spiq_pkg::REG_CAPACITY)
                     ? {{(32 - spiq_pkg::CAP_W){1'b0}}, capacity_ff} : '0;

   // Input transfer; the stored value keeps the low DATA_WIDTH bits.
   assign req_tready = idle;
   assign start      = req_tvalid && req_tready;
   assign value_ext  = {{DATA_WIDTH{1'b0}}, req_tdata[31:0]};
   assign value_fit  = value_ext[DATA_WIDTH-1:0];

   spiq_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_op       (req_tuser),
      .req_value    (value_fit),
      .req_priority (req_tdata[63:32]),
      .capacity     (capacity_ff),
      .out_free     (out_free),
      .idle         (idle),
      .res_valid    (res_valid),
      .res          (res),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data)
   );

   spiq_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Output register: loads a finished result whenever it is empty or being taken.
   assign out_free = !rsp_valid_ff || rsp_tready;
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_ff.status, rsp_ff.is_full, rsp_ff.is_empty,
                        rsp_ff.entry_count, rsp_ff.front_value};

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= spiq_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

FILE: hdl/spiq_checker.sv
// Port-level checks for the sorted-insert priority queue, bound to the top level.
module spiq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // Reset drops any pending result.
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result still valid after reset");

   // A stalled result holds its value.
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or vanished");

   // The queue works on one item at a time, so it is busy right after a transfer.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken on two consecutive cycles");

   // An empty queue reports a zero count and a zero front value.
   a_empty_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[37] |-> (rsp_tdata[36:32] == 5'd0)
                                      && (rsp_tdata[31:0] == 32'd0))
      else $error("empty flag inconsistent with count or front value");

   // A refused push only happens while the queue reports full.
   a_refusal_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[40:39] == 2'd2) |-> rsp_tdata[38])
      else $error("push refused while queue not full");

endmodule

bind sorted_insert_priority_queue_top spiq_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
